@@ design/opi_pkg.sv @@
`timescale 1ns / 1ps

package opi_pkg;

  // Default number of CORDIC micro-rotations (legal range 8 to 24)
  localparam int CordicSteps = 16;
  // Width of an index into the arctangent table (24 entries)
  localparam int AtanIdxW    = 5;

  // Shared multiplier geometry
  localparam int MulAW  = 35;
  localparam int MulBW  = 32;
  localparam int ProdW  = MulAW + MulBW;

  // Fixed-point constants
  localparam logic signed [31:0] GainQ30       = 32'sd652032874;   // CORDIC gain, Q2.30
  localparam logic signed [31:0] PiQ29         = 32'sd1686629713;  // pi, Q3.29
  localparam logic signed [31:0] TurnPerRadQ32 = 32'sd683565276;   // 2^32 / (2*pi)

  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] yaw_rate;
    logic        [15:0] time_step;
  } opi_in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic        [15:0] heading;
  } opi_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_D,
    ST_MID,
    ST_MUL_Z,
    ST_CINIT,
    ST_CORD,
    ST_MUL_XC,
    ST_MUL_YS,
    ST_MUL_XS,
    ST_MUL_YC,
    ST_MUL_WX,
    ST_MUL_WY,
    ST_UPD_X,
    ST_UPD_Y,
    ST_EMIT
  } opi_state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_P,
    OP_MUL_D,
    OP_MID,
    OP_MUL_Z,
    OP_CINIT,
    OP_CORD,
    OP_MUL_XC,
    OP_MUL_YS,
    OP_MUL_XS,
    OP_MUL_YC,
    OP_MUL_WX,
    OP_MUL_WY,
    OP_UPD_X,
    OP_UPD_Y,
    OP_EMIT
  } opi_op_t;

  typedef struct packed {
    opi_op_t               op;
    logic [AtanIdxW-1:0]   iter;
  } opi_cmd_t;

  typedef struct packed {
    logic out_free;
  } opi_sts_t;

  // atan(2^-i) in Q2.30, truncated
  function automatic logic [31:0] atan_q30(input logic [AtanIdxW-1:0] idx);
    logic [31:0] val;
    case (idx)
      5'd0:    val = 32'h3243F6A8;
      5'd1:    val = 32'h1DAC6705;
      5'd2:    val = 32'h0FADBAFC;
      5'd3:    val = 32'h07F56EA6;
      5'd4:    val = 32'h03FEAB76;
      5'd5:    val = 32'h01FFD55B;
      5'd6:    val = 32'h00FFFAAA;
      5'd7:    val = 32'h007FFF55;
      5'd8:    val = 32'h003FFFEA;
      5'd9:    val = 32'h001FFFFD;
      5'd10:   val = 32'h000FFFFF;
      5'd11:   val = 32'h0007FFFF;
      5'd12:   val = 32'h0003FFFF;
      5'd13:   val = 32'h0001FFFF;
      5'd14:   val = 32'h0000FFFF;
      5'd15:   val = 32'h00007FFF;
      5'd16:   val = 32'h00003FFF;
      5'd17:   val = 32'h00001FFF;
      5'd18:   val = 32'h00000FFF;
      5'd19:   val = 32'h000007FF;
      5'd20:   val = 32'h000003FF;
      5'd21:   val = 32'h000001FF;
      5'd22:   val = 32'h000000FF;
      5'd23:   val = 32'h0000007F;
      default: val = 32'h00000000;
    endcase
    return val;
  endfunction

endpackage

@@ design/opi_ctrl.sv @@
`timescale 1ns / 1ps

module opi_ctrl #(
  parameter int CORDIC_STEPS = opi_pkg::CordicSteps
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  opi_pkg::opi_sts_t sts,
  output opi_pkg::opi_cmd_t cmd
);

  localparam int IterW = $clog2(CORDIC_STEPS);

  opi_pkg::opi_state_t state_r, state_nxt;
  logic [IterW-1:0]    cnt_r, cnt_nxt;
  logic                cord_last;

  assign cord_last = (cnt_r == IterW'(CORDIC_STEPS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= opi_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      opi_pkg::ST_IDLE:   if (in_valid) state_nxt = opi_pkg::ST_MUL_P;
      opi_pkg::ST_MUL_P:  state_nxt = opi_pkg::ST_MUL_D;
      opi_pkg::ST_MUL_D:  state_nxt = opi_pkg::ST_MID;
      opi_pkg::ST_MID:    state_nxt = opi_pkg::ST_MUL_Z;
      opi_pkg::ST_MUL_Z:  state_nxt = opi_pkg::ST_CINIT;
      opi_pkg::ST_CINIT: begin
        cnt_nxt   = '0;
        state_nxt = opi_pkg::ST_CORD;
      end
      opi_pkg::ST_CORD: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cord_last) state_nxt = opi_pkg::ST_MUL_XC;
      end
      opi_pkg::ST_MUL_XC: state_nxt = opi_pkg::ST_MUL_YS;
      opi_pkg::ST_MUL_YS: state_nxt = opi_pkg::ST_MUL_XS;
      opi_pkg::ST_MUL_XS: state_nxt = opi_pkg::ST_MUL_YC;
      opi_pkg::ST_MUL_YC: state_nxt = opi_pkg::ST_MUL_WX;
      opi_pkg::ST_MUL_WX: state_nxt = opi_pkg::ST_MUL_WY;
      opi_pkg::ST_MUL_WY: state_nxt = opi_pkg::ST_UPD_X;
      opi_pkg::ST_UPD_X:  state_nxt = opi_pkg::ST_UPD_Y;
      opi_pkg::ST_UPD_Y:  state_nxt = opi_pkg::ST_EMIT;
      opi_pkg::ST_EMIT:   if (sts.out_free) state_nxt = opi_pkg::ST_IDLE;
      default:            state_nxt = opi_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready = 1'b0;
    cmd.op   = opi_pkg::OP_NONE;
    cmd.iter = opi_pkg::AtanIdxW'(cnt_r);
    case (state_r)
      opi_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = opi_pkg::OP_LOAD;
      end
      opi_pkg::ST_MUL_P:  cmd.op = opi_pkg::OP_MUL_P;
      opi_pkg::ST_MUL_D:  cmd.op = opi_pkg::OP_MUL_D;
      opi_pkg::ST_MID:    cmd.op = opi_pkg::OP_MID;
      opi_pkg::ST_MUL_Z:  cmd.op = opi_pkg::OP_MUL_Z;
      opi_pkg::ST_CINIT:  cmd.op = opi_pkg::OP_CINIT;
      opi_pkg::ST_CORD:   cmd.op = opi_pkg::OP_CORD;
      opi_pkg::ST_MUL_XC: cmd.op = opi_pkg::OP_MUL_XC;
      opi_pkg::ST_MUL_YS: cmd.op = opi_pkg::OP_MUL_YS;
      opi_pkg::ST_MUL_XS: cmd.op = opi_pkg::OP_MUL_XS;
      opi_pkg::ST_MUL_YC: cmd.op = opi_pkg::OP_MUL_YC;
      opi_pkg::ST_MUL_WX: cmd.op = opi_pkg::OP_MUL_WX;
      opi_pkg::ST_MUL_WY: cmd.op = opi_pkg::OP_MUL_WY;
      opi_pkg::ST_UPD_X:  cmd.op = opi_pkg::OP_UPD_X;
      opi_pkg::ST_UPD_Y:  cmd.op = opi_pkg::OP_UPD_Y;
      opi_pkg::ST_EMIT:   if (sts.out_free) cmd.op = opi_pkg::OP_EMIT;
      default:            cmd.op = opi_pkg::OP_NONE;
    endcase
  end

endmodule

@@ design/opi_datapath.sv @@
`timescale 1ns / 1ps

module opi_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  opi_pkg::opi_cmd_t cmd,
  output opi_pkg::opi_sts_t sts,
  input  opi_pkg::opi_in_t  in_data,
  output opi_pkg::opi_out_t out_data,
  output logic              out_valid,
  input  logic              out_ready
);

  localparam int ProdW = opi_pkg::ProdW;

  // saturate acc + d to 32 bits
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] acc,
                                                 input logic signed [35:0] d);
    logic signed [36:0] sum;
    logic signed [31:0] res;
    sum = 37'(acc) + 37'(d);
    if (sum[36:31] == 6'b000000 || sum[36:31] == 6'b111111) begin
      res = sum[31:0];
    end else if (sum[36]) begin
      res = 32'sh8000_0000;
    end else begin
      res = 32'sh7FFF_FFFF;
    end
    return res;
  endfunction

  opi_pkg::opi_in_t  in_r;
  opi_pkg::opi_out_t out_r;
  logic              out_valid_r;

  logic signed [31:0]       acc_x_r, acc_y_r;
  logic        [15:0]       head_r;
  logic        [15:0]       mid_r, full_r;
  logic        [1:0]        q_r;
  logic signed [31:0]       x_r, y_r, z_r;
  logic signed [ProdW-1:0]  prod_r, acc_r;
  logic signed [34:0]       wx_r, wy_r;
  logic signed [35:0]       dx_r, dy_r;

  logic signed [opi_pkg::MulAW-1:0] mul_a;
  logic signed [opi_pkg::MulBW-1:0] mul_b;
  logic signed [ProdW-1:0]          prod;

  logic signed [31:0] cos_v, sin_v;
  logic signed [31:0] x_sh, y_sh, atan_v;
  logic        [48:0] d_full, d_half;
  logic        [15:0] mid_bias;
  logic signed [ProdW-1:0] diff_v, sum_v, rnd16_v;
  logic signed [opi_pkg::MulBW-1:0] dt_b;

  assign dt_b = signed'({16'b0, in_r.time_step});

  // Quadrant fold of the CORDIC vector
  always_comb begin
    case (q_r)
      2'd0: begin
        cos_v = x_r;
        sin_v = y_r;
      end
      2'd1: begin
        cos_v = -y_r;
        sin_v = x_r;
      end
      2'd2: begin
        cos_v = -x_r;
        sin_v = -y_r;
      end
      default: begin
        cos_v = y_r;
        sin_v = -x_r;
      end
    endcase
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      opi_pkg::OP_MUL_P: begin
        mul_a = 35'(in_r.yaw_rate);
        mul_b = dt_b;
      end
      opi_pkg::OP_MUL_D: begin
        mul_a = 35'(signed'(prod_r[47:16]));
        mul_b = opi_pkg::TurnPerRadQ32;
      end
      opi_pkg::OP_MUL_Z: begin
        mul_a = 35'(signed'(mid_r[13:0]));
        mul_b = opi_pkg::PiQ29;
      end
      opi_pkg::OP_MUL_XC: begin
        mul_a = 35'(in_r.vel_x);
        mul_b = cos_v;
      end
      opi_pkg::OP_MUL_YS: begin
        mul_a = 35'(in_r.vel_y);
        mul_b = sin_v;
      end
      opi_pkg::OP_MUL_XS: begin
        mul_a = 35'(in_r.vel_x);
        mul_b = sin_v;
      end
      opi_pkg::OP_MUL_YC: begin
        mul_a = 35'(in_r.vel_y);
        mul_b = cos_v;
      end
      opi_pkg::OP_MUL_WX: begin
        mul_a = wx_r;
        mul_b = dt_b;
      end
      opi_pkg::OP_MUL_WY: begin
        mul_a = wy_r;
        mul_b = dt_b;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = ProdW'(mul_a) * ProdW'(mul_b);

  assign d_full   = prod_r[48:0] + 49'h0_8000_0000;
  assign d_half   = prod_r[48:0] + 49'h1_0000_0000;
  assign mid_bias = mid_r + 16'h2000;
  assign x_sh     = x_r >>> cmd.iter;
  assign y_sh     = y_r >>> cmd.iter;
  assign atan_v   = signed'(opi_pkg::atan_q30(cmd.iter));
  assign diff_v   = acc_r - prod_r;
  assign sum_v    = acc_r + prod_r;
  assign rnd16_v  = prod_r + ProdW'(33'sh8000);

  // Working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      opi_pkg::OP_LOAD: in_r <= in_data;
      opi_pkg::OP_MUL_P,
      opi_pkg::OP_MUL_D,
      opi_pkg::OP_MUL_Z,
      opi_pkg::OP_MUL_XC: prod_r <= prod;
      opi_pkg::OP_MID: begin
        mid_r  <= head_r + d_half[48:33];
        full_r <= d_full[47:32];
      end
      opi_pkg::OP_CINIT: begin
        z_r <= prod_r[45:14];
        x_r <= opi_pkg::GainQ30;
        y_r <= '0;
      end
      opi_pkg::OP_CORD: begin
        if (!z_r[31]) begin
          x_r <= x_r - y_sh;
          y_r <= y_r + x_sh;
          z_r <= z_r - atan_v;
        end else begin
          x_r <= x_r + y_sh;
          y_r <= y_r - x_sh;
          z_r <= z_r + atan_v;
        end
      end
      opi_pkg::OP_MUL_YS,
      opi_pkg::OP_MUL_YC: begin
        prod_r <= prod;
        acc_r  <= prod_r + ProdW'(33'sh2000_0000);
      end
      opi_pkg::OP_MUL_XS: begin
        prod_r <= prod;
        wx_r   <= diff_v[64:30];
      end
      opi_pkg::OP_MUL_WX: begin
        prod_r <= prod;
        wy_r   <= sum_v[64:30];
      end
      opi_pkg::OP_MUL_WY: begin
        prod_r <= prod;
        dx_r   <= rnd16_v[51:16];
      end
      opi_pkg::OP_UPD_X: dy_r <= rnd16_v[51:16];
      opi_pkg::OP_EMIT: begin
        out_r.pos_x   <= acc_x_r;
        out_r.pos_y   <= acc_y_r;
        out_r.heading <= head_r;
      end
      default: ;
    endcase
    if (cmd.op == opi_pkg::OP_MUL_Z) begin
      q_r <= mid_bias[15:14];
    end
  end

  // Pose state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_x_r <= '0;
      acc_y_r <= '0;
      head_r  <= '0;
    end else begin
      if (cmd.op == opi_pkg::OP_UPD_X) begin
        acc_x_r <= sat_add(acc_x_r, dx_r);
      end
      if (cmd.op == opi_pkg::OP_UPD_Y) begin
        acc_y_r <= sat_add(acc_y_r, dy_r);
        head_r  <= head_r + full_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == opi_pkg::OP_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_data     = out_r;

endmodule

@@ design/odometry_pose_integrator.sv @@
`timescale 1ns / 1ps

// Planar dead-reckoning pose integrator (midpoint / RK2). Each input beat
// carries body-frame vel_x, vel_y (Q16.16 m/s), yaw_rate (Q16.16 rad/s) and
// time_step (Q0.16 s). The block rotates the body velocity into the world
// frame at the heading half-way through the step, scales it by time_step,
// adds it to the saturating Q16.16 position, then advances the 16-bit
// binary-angle heading (65536 = one turn) and returns the new pose as one
// output beat. Pose resets to the origin with heading zero. After a beat is
// accepted, in_ready stays low until the result is emitted, so a new beat is
// only taken once the last one is through. The schedule is the accepting
// state, one step per CORDIC micro-rotation and 14 fixed steps (nine
// products on the single shared 35x32 multiplier, the midpoint angle, the
// CORDIC setup, two position updates and the emit). The result sits in an
// output register, so a beat that the sink has not taken yet only delays
// the block when the next result is ready to be written.

module odometry_pose_integrator #(
  parameter int CORDIC_STEPS = opi_pkg::CordicSteps
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  opi_pkg::opi_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output opi_pkg::opi_out_t out_data
);

  opi_pkg::opi_cmd_t cmd;
  opi_pkg::opi_sts_t sts;

  // Sequencer: walks the multiply schedule and the CORDIC iterations
  opi_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: operand latch, shared multiplier, CORDIC, pose and output regs
  opi_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

  // Hold off new input for at least the cycle after a beat is taken
  a_busy_after_accept : assert property (
    @(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready
  ) else $error("input accepted back to back");

  // Never overwrite a result that the sink has not taken
  a_emit_free : assert property (
    @(posedge clk) disable iff (!rst_n)
    (cmd.op == opi_pkg::OP_EMIT) |-> (!out_valid || out_ready)
  ) else $error("output register overwritten");

  // Latch operands only on an accepted beat
  a_load_accept : assert property (
    @(posedge clk) disable iff (!rst_n)
    (cmd.op == opi_pkg::OP_LOAD) |-> (in_valid && in_ready)
  ) else $error("operands latched without a beat");

  // A fresh result follows every emit
  a_emit_valid : assert property (
    @(posedge clk) disable iff (!rst_n)
    (cmd.op == opi_pkg::OP_EMIT) |=> out_valid
  ) else $error("emitted result not presented");

endmodule

@@ test/odometry_pose_integrator_tb.sv @@
`timescale 1ns / 1ps

module odometry_pose_integrator_tb;

  // Keep the integrator model on the same micro-rotation count as the block.
  localparam int NumRot = opi_pkg::CordicSteps;
  localparam int RotCap = 24;

  // Fixed-point constants of the integrator, Q2.30 / Q3.29 / Q32 as noted.
  localparam longint CordicGain = 64'sd652032874;
  localparam longint PiQ29      = 64'sd1686629713;
  localparam longint TurnPerRad = 64'sd683565276;
  localparam longint PosMax     = 64'sd2147483647;
  localparam longint PosMin     = -64'sd2147483648;

  localparam logic signed [31:0] S32Max = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32Min = 32'sh8000_0000;
  localparam logic signed [31:0] OneQ16 = 32'sh0001_0000;
  localparam logic signed [31:0] PiQ16  = 32'sd205887;
  localparam logic [15:0]        DtMax  = 16'hFFFF;
  localparam logic [15:0]        DtHalf = 16'h8000;

  // Settle time after the last beat.
  localparam int DrainCycles = NumRot + 40;
  localparam int MaxPrinted  = 100;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  opi_pkg::opi_in_t  in_data;
  logic              out_valid;
  logic              out_ready;
  opi_pkg::opi_out_t out_data;

  // Arctangent of 2^-i in Q2.30, truncated.
  longint atan_tab [0:23] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
  };

  // Model copy of the pose accumulators.
  longint      model_x;
  longint      model_y;
  logic [15:0] model_hdg;

  opi_pkg::opi_out_t pose_q[$];
  opi_pkg::opi_out_t want_pose;
  int                mismatch_cnt;
  int                src_idle_pct;
  int                sink_stall_pct;

  odometry_pose_integrator #(
    .CORDIC_STEPS(NumRot)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Advance the model pose by one step (midpoint integration) and return the new pose.
  function automatic opi_pkg::opi_out_t advance_pose(input opi_pkg::opi_in_t stp);
    longint            vx, vy, wz, dt, d, z, x, y, nx, c, sn, wx, wy, acc;
    logic [63:0]       du;
    logic [15:0]       full_inc, half_inc, mid, qsum, rsd;
    logic [1:0]        quad;
    opi_pkg::opi_out_t res;
    vx = longint'($signed(stp.vel_x));
    vy = longint'($signed(stp.vel_y));
    wz = longint'($signed(stp.yaw_rate));
    dt = longint'(stp.time_step);

    // Angle increment in binary-angle units with 32 fraction bits.
    d  = ((wz * dt) >>> 16) * TurnPerRad;
    du = d;
    full_inc = 16'((du + 64'h0000_0000_8000_0000) >> 32);
    half_inc = 16'((du + 64'h0000_0001_0000_0000) >> 33);
    mid = model_hdg + half_inc;

    // Fold the midpoint angle into one quadrant, then rotate a unit vector.
    qsum = mid + 16'h2000;
    quad = qsum[15:14];
    rsd  = mid - {quad, 14'd0};
    z = (longint'($signed(rsd)) * PiQ29) >>> 14;
    x = CordicGain;
    y = 0;
    for (int i = 0; i < NumRot && i < RotCap; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - atan_tab[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + atan_tab[i];
      end
      x = nx;
    end
    case (quad)
      2'd0: begin c = x;  sn = y;  end
      2'd1: begin c = -y; sn = x;  end
      2'd2: begin c = -x; sn = -y; end
      default: begin c = y; sn = -x; end
    endcase

    // World-frame velocity, then displacement; both round half up.
    wx = (vx * c - vy * sn + 64'sd536870912) >>> 30;
    wy = (vx * sn + vy * c + 64'sd536870912) >>> 30;

    acc = model_x + ((wx * dt + 64'sd32768) >>> 16);
    model_x = (acc > PosMax) ? PosMax : (acc < PosMin) ? PosMin : acc;
    acc = model_y + ((wy * dt + 64'sd32768) >>> 16);
    model_y = (acc > PosMax) ? PosMax : (acc < PosMin) ? PosMin : acc;
    model_hdg = model_hdg + full_inc;

    res.pos_x   = model_x[31:0];
    res.pos_y   = model_y[31:0];
    res.heading = model_hdg;
    return res;
  endfunction

  task automatic flag_mismatch(input string field, input longint got, input longint want);
    if (mismatch_cnt < MaxPrinted)
      $display("%0t: %s got %0d, want %0d", $realtime, field, got, want);
    mismatch_cnt++;
  endtask

  // Send one step beat. Drop valid only when a gap is drawn, so back-to-back
  // beats keep valid high without a second assignment in the same time step.
  task automatic drive_step(input logic signed [31:0] vx, input logic signed [31:0] vy,
                            input logic signed [31:0] wz, input logic [15:0] dt);
    opi_pkg::opi_in_t stp;
    stp.vel_x     = vx;
    stp.vel_y     = vy;
    stp.yaw_rate  = wz;
    stp.time_step = dt;
    if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= stp;
    // Hold the beat until the block takes it.
    do @(posedge clk); while (!in_ready);
    pose_q.push_back(advance_pose(stp));
  endtask

  // Drop valid and wait until every expected pose has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pose_q.size() != 0);
  endtask

  // Zero time steps leave the pose unchanged whatever the velocities; one beat has a time step of 1.
  task automatic test_zero_step();
    drive_step(S32Max, S32Min, S32Max, 16'd0);
    drive_step(S32Min, S32Max, S32Min, 16'd0);
    drive_step(OneQ16, OneQ16, 32'sd0, 16'd1);
    drive_step(-OneQ16, 32'sd0, 32'sd0, 16'd0);
  endtask

  // Step the heading about a quarter turn at a time so the midpoint angle
  // visits every quadrant and lands near the quadrant fold boundaries.
  task automatic test_quadrants();
    repeat (5) drive_step(OneQ16, OneQ16 >>> 1, PiQ16, DtHalf);
    repeat (3) drive_step(-OneQ16, OneQ16, -PiQ16, DtHalf);
  endtask

  // Extremes of every field.
  task automatic test_extremes();
    drive_step(S32Max, 32'sd0, 32'sd0, DtMax);
    drive_step(S32Min, 32'sd0, 32'sd0, DtMax);
    drive_step(32'sd0, S32Max, S32Max, DtMax);
    drive_step(32'sd0, S32Min, S32Min, DtMax);
    drive_step(S32Min, S32Min, S32Max, 16'd1);
  endtask

  // Drive both position accumulators into each rail and back out.
  task automatic test_saturation();
    repeat (3) drive_step(S32Max, S32Max, 32'sd0, DtMax);
    repeat (4) drive_step(S32Min, S32Min, 32'sd0, DtMax);
  endtask

  // Heading wraps past one full turn in both directions.
  task automatic test_heading_wrap();
    drive_step(32'sd0, 32'sd0, S32Max, DtMax);
    drive_step(32'sd0, 32'sd0, S32Min, DtMax);
    drive_step(OneQ16, 32'sd0, 32'sd411774, DtMax);
  endtask

  // Random steps: mostly realistic speeds and rates, sometimes full range,
  // with zero and maximal time steps mixed in.
  task automatic test_random(input int n_steps, input int src_pct, input int sink_pct);
    logic signed [31:0] vx, vy, wz;
    logic [15:0]        dt;
    wait_idle();
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    repeat (n_steps) begin
      vx = ($urandom_range(7) == 0) ? $urandom : $urandom_range(2097152) - 32'd1048576;
      vy = ($urandom_range(7) == 0) ? $urandom : $urandom_range(524288) - 32'd262144;
      wz = ($urandom_range(7) == 0) ? $urandom : $urandom_range(524288) - 32'd262144;
      case ($urandom_range(15))
        0:       dt = 16'd0;
        1:       dt = DtMax;
        2, 3, 4: dt = 16'($urandom_range(1310));
        default: dt = 16'($urandom);
      endcase
      drive_step(vx, vy, wz, dt);
    end
  endtask

  // Sink side: stall at random at the rate of the current phase.
  always @(posedge clk) begin
    out_ready <= (sink_stall_pct == 0) || ($urandom_range(99) >= sink_stall_pct);
  end

  // Compare each accepted pose beat with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pose_q.size() == 0) begin
        flag_mismatch("unexpected pose beat, pos_x", longint'($signed(out_data.pos_x)), 0);
      end else begin
        want_pose = pose_q.pop_front();
        if (out_data.pos_x !== want_pose.pos_x)
          flag_mismatch("pos_x", longint'($signed(out_data.pos_x)),
                        longint'($signed(want_pose.pos_x)));
        if (out_data.pos_y !== want_pose.pos_y)
          flag_mismatch("pos_y", longint'($signed(out_data.pos_y)),
                        longint'($signed(want_pose.pos_y)));
        if (out_data.heading !== want_pose.heading)
          flag_mismatch("heading", longint'(out_data.heading), longint'(want_pose.heading));
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_ready      = 1'b0;
    mismatch_cnt   = 0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    model_x        = 0;
    model_y        = 0;
    model_hdg      = 16'd0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_zero_step();
    test_quadrants();
    test_extremes();
    test_saturation();
    test_heading_wrap();

    test_random(340, 0, 0);
    test_random(340, 80, 0);
    test_random(340, 0, 80);
    test_random(330, 38, 38);

    wait_idle();
    repeat (DrainCycles) @(posedge clk);
    if (pose_q.size() != 0)
      flag_mismatch("pose beats still outstanding", pose_q.size(), 0);
    if (mismatch_cnt == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
